@@ rtl/core/mdsr_pkg.sv @@
// Shared types, constants and control structs of the multidrop slave frame responder.
package mdsr_pkg;

  // Default largest data length held in the frame store
  localparam int MDSR_MAX_DATA_DEF = 8;

  // Station address after reset
  localparam logic [7:0] STATION_RESET = 8'h02;

  // Master address, slave address and length lead every frame
  localparam logic [8:0] HEAD_BYTES = 9'd3;
  // Head bytes plus checksum
  localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

  // Received word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       address_mark;
  } mdsr_in_t;

  // Transmitted word
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_address_mark;
    logic       frame_ok;
    logic       last_byte;
  } mdsr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic take_addr;    // matching address word: queue the address reply
    logic take_data;    // data word inside a frame: store, count, sum
    logic start_reply;  // frame complete: prime the reply readout
    logic emit_good;    // send next word of a good-frame reply
    logic emit_bad;     // send next word of a bad-frame reply
  } mdsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic data_byte;    // incoming word has its ninth bit clear
    logic addr_hit;     // incoming word is our address
    logic frame_end;    // incoming word is the frame's checksum
    logic frame_good;   // checksum matches and length fits
    logic out_free;     // output register can take a word this cycle
    logic last_good;    // next good-reply word is the closing sum
    logic last_bad;     // next bad-reply word is the last one
  } mdsr_stat_t;

endpackage

@@ rtl/core/multidrop_slave_frame_responder_top.sv @@
// Top level of the multidrop slave frame responder.
//
//  channel | direction | handshake         | word
//  in_     | input     | in_valid/in_stall | mdsr_in_t (rx_byte, address_mark)
//  out_    | output    | out_valid/out_stall | mdsr_out_t (tx_byte, marks, flags)
//  cfg_    | input     | cfg_valid/cfg_ready | station address, 8 bits
//
// A received word is taken unless in_stall is high; the matching address reply
// is loaded into the output register in that same cycle.
// A good frame's reply (length + 3 words) leaves at one word per cycle while the
// output is not stalled, paced by the frame store's single registered read port;
// a bad frame's reply takes 3. The input is stalled while a reply runs, and when
// idle while the output register holds a stalled word.
// Reset is synchronous; the frame store needs no clearing pass after it.
module multidrop_slave_frame_responder_top
  import mdsr_pkg::*;
#(
  parameter int MAX_DATA = MDSR_MAX_DATA_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mdsr_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output mdsr_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  mdsr_cmd_t  cmd;
  mdsr_stat_t stat;

  // Station register always takes a write
  assign cfg_ready = 1'b1;

  mdsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdsr_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ rtl/core/mdsr_ctrl.sv @@
// Link-mode state machine of the multidrop slave frame responder.
module mdsr_ctrl
  import mdsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mdsr_stat_t stat,
  output mdsr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_FRAME     = 3'd1;
  localparam logic [2:0] S_CLOSE     = 3'd2;
  localparam logic [2:0] S_SEND_GOOD = 3'd3;
  localparam logic [2:0] S_SEND_BAD  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state, commands and input stall
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_FRAME: begin
        in_stall = 1'b0;
        if (in_valid && stat.data_byte) begin
          cmd.take_data = 1'b1;
          if (stat.frame_end) begin
            cmd.start_reply = 1'b1;
            state_nxt = stat.frame_good ? S_SEND_GOOD : S_SEND_BAD;
          end
        end
      end
      S_CLOSE: begin
        // closing frame is framed but never answered
        in_stall = 1'b0;
        if (in_valid && stat.data_byte) begin
          cmd.take_data = 1'b1;
          if (stat.frame_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SEND_GOOD: begin
        if (stat.out_free) begin
          cmd.emit_good = 1'b1;
          if (stat.last_good) begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_SEND_BAD: begin
        if (stat.out_free) begin
          cmd.emit_bad = 1'b1;
          if (stat.last_bad) begin
            state_nxt = S_FRAME;
          end
        end
      end
      default: begin
        // idle, and any unused code behaves as idle
        state_nxt = S_IDLE;
        in_stall  = !stat.out_free;
        if (in_valid && stat.out_free && stat.addr_hit) begin
          cmd.take_addr = 1'b1;
          state_nxt = S_FRAME;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // No input word is taken while a reply runs
  a_stall_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND_GOOD || state_r == S_SEND_BAD) |-> in_stall)
    else $error("input taken during reply");

  // A completed frame outside the closing mode always leads into a reply
  a_reply_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_reply |=> (state_r == S_SEND_GOOD || state_r == S_SEND_BAD))
    else $error("frame end without reply");

  // Good reply ends in the closing mode
  a_good_to_close: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_good && stat.last_good) |=> state_r == S_CLOSE)
    else $error("good reply did not enter closing mode");

endmodule

@@ rtl/core/mdsr_dp.sv @@
// Datapath: station register, frame store, byte count, sums and output register.
module mdsr_dp
  import mdsr_pkg::*;
#(
  parameter int MAX_DATA = MDSR_MAX_DATA_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  mdsr_in_t   in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output mdsr_out_t  out_data,
  input  mdsr_cmd_t  cmd,
  output mdsr_stat_t stat
);

  localparam int DEPTH = MAX_DATA + 4;
  localparam int SW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DATA + 3);

  logic [7:0]  station_r;
  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  store_mem [DEPTH];
  logic [7:0]  rd_data_r;
  logic [KW-1:0] k_r, k_nxt;
  logic [7:0]  reply_sum_r, reply_sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  mdsr_out_t   out_data_r, out_data_nxt;

  logic [8:0]    cnt_inc;
  logic [8:0]    frame_len;
  logic [8:0]    pf_idx;
  logic          pf_ok;
  logic          wr_ok;

  assign cnt_inc   = byte_count_r + 9'd1;
  assign frame_len = {1'b0, len_r} + FRAME_OVERHEAD;
  assign pf_idx    = 9'(k_r) + 9'd2;
  assign pf_ok     = pf_idx < 9'(DEPTH);
  assign wr_ok     = byte_count_r < 9'(DEPTH);

  // Status towards the controller
  always_comb begin
    stat.data_byte  = !in_data.address_mark;
    stat.addr_hit   = in_data.address_mark && (in_data.rx_byte == station_r);
    // length is known once the head is in
    stat.frame_end  = (byte_count_r >= HEAD_BYTES) && (cnt_inc == frame_len);
    stat.frame_good = (len_r <= 8'(MAX_DATA)) && (running_sum_r == in_data.rx_byte);
    stat.out_free   = !out_valid_r || !out_stall;
    stat.last_good  = 9'(k_r) == ({1'b0, len_r} + 9'd2);
    stat.last_bad   = k_r == KW'(2);
  end

  // Frame counting and summing
  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    len_nxt         = len_r;
    if (cmd.take_addr) begin
      byte_count_nxt  = '0;
      running_sum_nxt = '0;
    end else if (cmd.take_data) begin
      if (byte_count_r == 9'd2) begin
        len_nxt = in_data.rx_byte;
      end
      if (stat.frame_end) begin
        byte_count_nxt  = '0;
        running_sum_nxt = '0;
      end else begin
        byte_count_nxt  = cnt_inc;
        running_sum_nxt = running_sum_r + in_data.rx_byte;
      end
    end
  end

  // Reply sequencing and output register
  always_comb begin
    k_nxt         = k_r;
    reply_sum_nxt = reply_sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.start_reply) begin
      k_nxt         = '0;
      reply_sum_nxt = '0;
    end
    if (cmd.take_addr) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{tx_byte: station_r, tx_address_mark: 1'b1,
                        frame_ok: 1'b0, last_byte: 1'b1};
    end else if (cmd.emit_good) begin
      out_valid_nxt = 1'b1;
      k_nxt         = k_r + KW'(1);
      reply_sum_nxt = reply_sum_r + rd_data_r;
      if (stat.last_good) begin
        out_data_nxt = '{tx_byte: reply_sum_r, tx_address_mark: 1'b0,
                         frame_ok: 1'b1, last_byte: 1'b1};
      end else begin
        out_data_nxt = '{tx_byte: rd_data_r, tx_address_mark: 1'b0,
                         frame_ok: 1'b1, last_byte: 1'b0};
      end
    end else if (cmd.emit_bad) begin
      // slave address, zero, then their sum (the address again)
      out_valid_nxt = 1'b1;
      k_nxt         = k_r + KW'(1);
      out_data_nxt  = '{tx_byte: (k_r == KW'(1)) ? 8'h00 : rd_data_r,
                        tx_address_mark: 1'b0, frame_ok: 1'b0,
                        last_byte: stat.last_bad};
    end
  end

  // Frame store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.take_data && wr_ok) begin
      store_mem[byte_count_r[SW-1:0]] <= in_data.rx_byte;
    end
    if (cmd.start_reply) begin
      rd_data_r <= store_mem[SW'(1)];
    end else if (cmd.emit_good && pf_ok) begin
      rd_data_r <= store_mem[pf_idx[SW-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    k_r         <= k_nxt;
    reply_sum_r <= reply_sum_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r     <= STATION_RESET;
      byte_count_r  <= '0;
      running_sum_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        station_r <= cfg_data;
      end
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Address reply carries the station address with the ninth bit set
  a_addr_reply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_addr |=> out_valid_r && out_data_r.tx_address_mark &&
                      out_data_r.last_byte && out_data_r.tx_byte == $past(station_r))
    else $error("bad address reply");

  // Closing sum word of a good reply is flagged last
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_good && stat.last_good) |=> out_valid_r && out_data_r.last_byte &&
                                          out_data_r.frame_ok)
    else $error("good reply not closed");

  // Byte count never runs past the frame's end
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_count_r > HEAD_BYTES) |-> (byte_count_r < frame_len))
    else $error("byte count beyond frame end");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the multidrop slave frame responder.
module tb_top;
  import mdsr_pkg::*;

  localparam int MAX_DATA       = MDSR_MAX_DATA_DEF;
  localparam int STORE_DEPTH    = MAX_DATA + 4;
  localparam int CLK_PERIOD     = 12;
  localparam int SETTLE_CYCLES  = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_WORDS    = 70;
  localparam int TIMEOUT_CYCLES = 400000;

  // Link modes of the slave as the checker follows them
  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_FRAME,
    LINK_CLOSING
  } link_mode_e;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  mdsr_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  mdsr_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'h00;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int words_sent     = 0;

  // Follows the slave's frame handling and keeps the reply words still owed
  class reply_scoreboard;
    logic [7:0]  station;
    link_mode_e  mode;
    logic [7:0]  store [STORE_DEPTH];
    int          count;
    logic [7:0]  sum;
    mdsr_out_t   pending_replies [$];
    int          mismatches;

    function new();
      station    = STATION_RESET;
      mode       = LINK_IDLE;
      count      = 0;
      sum        = 8'h00;
      mismatches = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void queue_reply(logic [7:0] b, logic mark, logic ok, logic last);
      mdsr_out_t r;
      r.tx_byte         = b;
      r.tx_address_mark = mark;
      r.frame_ok        = ok;
      r.last_byte       = last;
      pending_replies.push_back(r);
    endfunction

    // Accepted received word: advance the link state, queue any reply
    function void take_rx_word(mdsr_in_t w);
      logic [7:0] b;
      logic [7:0] len;
      logic [7:0] acc;
      logic       good;
      int         i;
      b = w.rx_byte;
      if (mode == LINK_IDLE) begin
        if (w.address_mark && b == station) begin
          queue_reply(station, 1'b1, 1'b0, 1'b1);
          mode  = LINK_FRAME;
          count = 0;
          sum   = 8'h00;
        end
        return;
      end
      // address words inside a frame are dropped
      if (w.address_mark) return;
      if (count < STORE_DEPTH) store[count] = b;
      count++;
      if (!(count >= 3 && count == 4 + int'(store[2]))) begin
        sum = sum + b;
        return;
      end
      // b is the checksum
      len = store[2];
      if (mode == LINK_CLOSING) begin
        mode  = LINK_IDLE;
        count = 0;
        sum   = 8'h00;
        return;
      end
      good  = (int'(len) <= MAX_DATA) && (sum == b);
      count = 0;
      sum   = 8'h00;
      if (good) begin
        acc = 8'h00;
        for (i = 0; i < int'(len) + 2; i++) begin
          queue_reply(store[i + 1], 1'b0, 1'b1, 1'b0);
          acc = acc + store[i + 1];
        end
        queue_reply(acc, 1'b0, 1'b1, 1'b1);
        mode = LINK_CLOSING;
      end else begin
        queue_reply(store[1], 1'b0, 1'b0, 1'b0);
        queue_reply(8'h00, 1'b0, 1'b0, 1'b0);
        queue_reply(store[1], 1'b0, 1'b0, 1'b1);
        mode = LINK_FRAME;
      end
    endfunction

    // Accepted transmitted word: compare with the oldest owed reply
    function void match_tx_word(mdsr_out_t got);
      mdsr_out_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected word: tx_byte %h mark %b", got.tx_byte, got.tx_address_mark);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
        mismatches++;
      end
      if (got.tx_address_mark !== want.tx_address_mark) begin
        $error("tx_address_mark: expected %b, got %b",
               want.tx_address_mark, got.tx_address_mark);
        mismatches++;
      end
      if (got.frame_ok !== want.frame_ok) begin
        $error("frame_ok: expected %b, got %b", want.frame_ok, got.frame_ok);
        mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %b, got %b", want.last_byte, got.last_byte);
        mismatches++;
      end
    endfunction
  endclass

  reply_scoreboard sb;

  multidrop_slave_frame_responder_top #(
    .MAX_DATA(MAX_DATA)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Safety net against a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: check words, random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.match_tx_word(out_data);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one word, with random idle cycles ahead of it, until taken
  task automatic send_word(input logic [7:0] b, input logic mark);
    mdsr_in_t w;
    w.rx_byte      = b;
    w.address_mark = mark;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_rx_word(w);
    words_sent++;
  endtask

  // Sender pause: let every owed reply drain, then some settling cycles
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.station = v;
  endtask

  // One data frame; a corrupt checksum never equals the real sum
  task automatic send_frame(input int len, input bit corrupt, input logic [7:0] slave);
    logic [7:0] acc;
    logic [7:0] v;
    int         i;
    acc = 8'h00;
    for (i = 0; i < len + 3; i++) begin
      if (i == 0)      v = 8'($urandom_range(255));
      else if (i == 1) v = slave;
      else if (i == 2) v = 8'(len);
      else             v = 8'($urandom_range(255));
      // stray address word mid-frame, dropped by the slave
      if ($urandom_range(24) == 0) send_word(8'($urandom_range(255)), 1'b1);
      send_word(v, 1'b0);
      acc = acc + v;
    end
    if (corrupt) acc = acc + 8'($urandom_range(1, 255));
    send_word(acc, 1'b0);
  endtask

  // A session: wake the slave, some rejected frames, a good one, closing frame; now and then just one random word
  task automatic run_session();
    logic [7:0] slave;
    int         n_bad;
    if ($urandom_range(9) == 0) begin
      send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    slave = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : sb.station;
    if (sb.mode == LINK_IDLE) begin
      if ($urandom_range(3) == 0)
        send_word(sb.station + 8'($urandom_range(1, 255)), 1'b1);
      if ($urandom_range(3) == 0) send_word(8'($urandom_range(255)), 1'b0);
      send_word(sb.station, 1'b1);
    end
    if (sb.mode == LINK_FRAME) begin
      n_bad = $urandom_range(2);
      repeat (n_bad) begin
        if ($urandom_range(1) == 0)
          send_frame($urandom_range(MAX_DATA), 1'b1, slave);
        else
          send_frame($urandom_range(MAX_DATA + 1, MAX_DATA + 6), 1'($urandom_range(1)), slave);
      end
      send_frame($urandom_range(MAX_DATA), 1'b0, slave);
    end
    if (sb.mode == LINK_CLOSING)
      send_frame($urandom_range(MAX_DATA), 1'($urandom_range(1)), slave);
  endtask

  initial begin
    int phase;
    int target;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle data word, foreign address, our address
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(STATION_RESET, 1'b1);
    // bad checksum with an address word in the middle
    send_word(8'h01, 1'b0);
    send_word(STATION_RESET, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h55, 1'b0);
    // good frame, one data word of all ones
    send_word(8'h80, 1'b0);
    send_word(STATION_RESET, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h82, 1'b0);
    // closing frame, empty, back to idle
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);

    // Random phases, each with its own station address and idling mix
    for (phase = 0; phase < 3; phase++) begin
      drain_replies();
      case (phase)
        0: begin
          write_station(8'h00);
          send_idle_pct  = 10;
          recv_stall_pct = 45;
        end
        1: begin
          write_station(8'hFF);
          send_idle_pct  = 45;
          recv_stall_pct = 10;
        end
        default: begin
          write_station(8'($urandom_range(1, 254)));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      // receiver holds off while the sender keeps pushing
      if (phase < 2) hold_asked++;
      // longest length the link allows, rejected as too long
      if (phase == 2) begin
        if (sb.mode == LINK_IDLE) send_word(sb.station, 1'b1);
        if (sb.mode == LINK_FRAME) send_frame(255, 1'b0, sb.station);
      end
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        run_session();
        if (words_sent > target - PHASE_WORDS / 2 && $urandom_range(19) == 0)
          drain_replies();
      end
    end

    drain_replies();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mdsr_pkg.sv
rtl/core/mdsr_ctrl.sv
rtl/core/mdsr_dp.sv
rtl/core/multidrop_slave_frame_responder_top.sv
test/tb_top.sv
